// ===== design/lwcc_pkg.sv =====
// Shared types, register codes and a helper function for the lattice walk collision checker.
// Every design file but lwcc_ram refers to this package by scoped names.
`default_nettype none
package lwcc_pkg;

    localparam int CFG_AW = 5;

    localparam logic [2:0] REG_DIM_MODE  = 3'd0;
    localparam logic [2:0] REG_DX_2D     = 3'd1;
    localparam logic [2:0] REG_DY_2D     = 3'd2;
    localparam logic [2:0] REG_DX_3D     = 3'd3;
    localparam logic [2:0] REG_DY_3D     = 3'd4;
    localparam logic [2:0] REG_DZ_3D     = 3'd5;
    localparam logic [2:0] REG_ORIGIN_2D = 3'd6;
    localparam logic [2:0] REG_ORIGIN_3D = 3'd7;

    localparam logic        RST_DIM_MODE  = 1'b0;
    localparam logic [7:0]  RST_DX_2D     = 8'd13;
    localparam logic [7:0]  RST_DY_2D     = 8'd208;
    localparam logic [11:0] RST_DX_3D     = 12'd13;
    localparam logic [11:0] RST_DY_3D     = 12'd208;
    localparam logic [11:0] RST_DZ_3D     = 12'd3328;
    localparam logic [5:0]  RST_ORIGIN_2D = 6'd32;
    localparam logic [3:0]  RST_ORIGIN_3D = 4'd8;

    localparam logic [2:0] DIRS_2D = 3'd4;
    localparam logic [2:0] DIRS_3D = 3'd6;

    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_BLOCKED = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;

    typedef struct packed {
        logic        dimension_mode;
        logic [7:0]  dx_table_2d;
        logic [7:0]  dy_table_2d;
        logic [11:0] dx_table_3d;
        logic [11:0] dy_table_3d;
        logic [11:0] dz_table_3d;
        logic [5:0]  origin_2d;
        logic [3:0]  origin_3d;
    } t_cfg;

    typedef struct packed {
        logic load_item;
        logic rd_occ;
        logic sel_latched;
        logic place_origin;
        logic resolve;
        logic release_run;
        logic clear_run;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic failed;
        logic last;
        logic out_free;
        logic release_done;
        logic clear_done;
    } t_sts;

    function automatic logic signed [1:0] delta_of(input logic [11:0] tbl,
                                                   input logic [2:0]  dir);
        logic [11:0] sh;
        sh = tbl >> {dir, 1'b0};
        return $signed(sh[1:0]);
    endfunction

endpackage
`default_nettype wire

// ===== design/lwcc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the occupancy store and the placed path store.
`default_nettype none
module lwcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/lwcc_cfg.sv =====
// Configuration register bank behind the APB-style port.
// Depends on lwcc_pkg for the register codes, reset values and the t_cfg type.
`default_nettype none
module lwcc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lwcc_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output lwcc_pkg::t_cfg                     o_cfg
);

    lwcc_pkg::t_cfg r_cfg;
    lwcc_pkg::t_cfg n_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                lwcc_pkg::REG_DIM_MODE:  n_cfg.dimension_mode = pwdata[0];
                lwcc_pkg::REG_DX_2D:     n_cfg.dx_table_2d    = pwdata[7:0];
                lwcc_pkg::REG_DY_2D:     n_cfg.dy_table_2d    = pwdata[7:0];
                lwcc_pkg::REG_DX_3D:     n_cfg.dx_table_3d    = pwdata[11:0];
                lwcc_pkg::REG_DY_3D:     n_cfg.dy_table_3d    = pwdata[11:0];
                lwcc_pkg::REG_DZ_3D:     n_cfg.dz_table_3d    = pwdata[11:0];
                lwcc_pkg::REG_ORIGIN_2D: n_cfg.origin_2d      = pwdata[5:0];
                lwcc_pkg::REG_ORIGIN_3D: n_cfg.origin_3d      = pwdata[3:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimension_mode <= lwcc_pkg::RST_DIM_MODE;
            r_cfg.dx_table_2d    <= lwcc_pkg::RST_DX_2D;
            r_cfg.dy_table_2d    <= lwcc_pkg::RST_DY_2D;
            r_cfg.dx_table_3d    <= lwcc_pkg::RST_DX_3D;
            r_cfg.dy_table_3d    <= lwcc_pkg::RST_DY_3D;
            r_cfg.dz_table_3d    <= lwcc_pkg::RST_DZ_3D;
            r_cfg.origin_2d      <= lwcc_pkg::RST_ORIGIN_2D;
            r_cfg.origin_3d      <= lwcc_pkg::RST_ORIGIN_3D;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            lwcc_pkg::REG_DIM_MODE:  prdata = {31'd0, r_cfg.dimension_mode};
            lwcc_pkg::REG_DX_2D:     prdata = {24'd0, r_cfg.dx_table_2d};
            lwcc_pkg::REG_DY_2D:     prdata = {24'd0, r_cfg.dy_table_2d};
            lwcc_pkg::REG_DX_3D:     prdata = {20'd0, r_cfg.dx_table_3d};
            lwcc_pkg::REG_DY_3D:     prdata = {20'd0, r_cfg.dy_table_3d};
            lwcc_pkg::REG_DZ_3D:     prdata = {20'd0, r_cfg.dz_table_3d};
            lwcc_pkg::REG_ORIGIN_2D: prdata = {26'd0, r_cfg.origin_2d};
            lwcc_pkg::REG_ORIGIN_3D: prdata = {28'd0, r_cfg.origin_3d};
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== design/lwcc_ctrl.sv =====
// Controller state machine: sequences clearing, origin placement, lookup, check and release.
// Depends on lwcc_pkg for the command and status structs.
`default_nettype none
module lwcc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  lwcc_pkg::t_sts      i_sts,
    output lwcc_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_ORIGIN  = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_CHECK   = 3'd4;
    localparam logic [2:0] ST_RELEASE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_run = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (!i_sts.started) begin
                        n_state = ST_ORIGIN;
                    end else begin
                        o_cmd.rd_occ = !i_sts.failed;
                        n_state      = ST_CHECK;
                    end
                end
            end
            ST_ORIGIN: begin
                o_cmd.place_origin = 1'b1;
                o_cmd.sel_latched  = 1'b1;
                n_state            = ST_READ;
            end
            ST_READ: begin
                o_cmd.sel_latched = 1'b1;
                o_cmd.rd_occ      = 1'b1;
                n_state           = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.sel_latched = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = i_sts.last ? ST_RELEASE : ST_IDLE;
                end
            end
            ST_RELEASE: begin
                o_cmd.release_run = 1'b1;
                if (i_sts.release_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== design/lwcc_dp.sv =====
// Datapath: step arithmetic, bounds check, occupancy and path stores, output register.
// Depends on lwcc_pkg and on lwcc_ram for both stores.
`default_nettype none
module lwcc_dp #(
    parameter int SIDE_2D   = 64,
    parameter int SIDE_3D   = 16,
    parameter int MAX_CHAIN = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  lwcc_pkg::t_cfg      i_cfg,
    input  lwcc_pkg::t_cmd      i_cmd,
    output lwcc_pkg::t_sts      o_sts,
    input  wire logic [2:0]     i_direction,
    input  wire logic           i_last_step,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic      [5:0]     o_pos_x,
    output logic      [5:0]     o_pos_y,
    output logic      [3:0]     o_pos_z,
    output logic      [1:0]     o_step_status,
    output logic                o_chain_end
);

    localparam int SIDE_MAX   = (SIDE_2D > SIDE_3D) ? SIDE_2D : SIDE_3D;
    localparam int CW         = $clog2(SIDE_MAX);
    localparam int ZW         = $clog2(SIDE_3D);
    localparam int SW         = CW + 2;
    localparam int ZSW        = ZW + 2;
    localparam int CELLS_2D   = SIDE_2D * SIDE_2D;
    localparam int CELLS_3D   = SIDE_3D * SIDE_3D * SIDE_3D;
    localparam int CELL_DEPTH = (CELLS_2D > CELLS_3D) ? CELLS_2D : CELLS_3D;
    localparam int AW         = $clog2(CELL_DEPTH);
    localparam int PW         = $clog2(MAX_CHAIN);
    localparam int BW         = $clog2(MAX_CHAIN + 1);

    logic [2:0]          r_dir;
    logic                r_last;
    logic [CW-1:0]       r_cur_x;
    logic [CW-1:0]       r_cur_y;
    logic [ZW-1:0]       r_cur_z;
    logic [BW-1:0]       r_beads;
    logic                r_failed;
    logic                r_started;
    logic [BW-1:0]       r_rel_idx;
    logic                r_rel_wr;
    logic [AW-1:0]       r_clr_idx;
    logic                r_out_valid;
    logic [5:0]          r_pos_x;
    logic [5:0]          r_pos_y;
    logic [3:0]          r_pos_z;
    logic [1:0]          r_status;
    logic                r_chain_end;

    logic                is3d;
    logic [2:0]          dir_raw;
    logic [2:0]          dir;
    logic signed [1:0]   dx;
    logic signed [1:0]   dy;
    logic signed [1:0]   dz;
    logic [8:0]          org_in;
    logic [8:0]          side9;
    logic [8:0]          org_sat;
    logic [CW-1:0]       org;
    logic [CW-1:0]       base_x;
    logic [CW-1:0]       base_y;
    logic [ZW-1:0]       base_z;
    logic signed [SW-1:0]  nx;
    logic signed [SW-1:0]  ny;
    logic signed [ZSW-1:0] nz;
    logic signed [SW-1:0]  side_s;
    logic signed [ZSW-1:0] side_z;
    logic                oob_x;
    logic                oob_y;
    logic                oob_z;
    logic                full;
    logic                blocked;
    logic                place_now;
    logic [CW-1:0]       ux;
    logic [CW-1:0]       uy;
    logic [ZW-1:0]       uz;
    logic [AW-1:0]       addr2;
    logic [AW-1:0]       addr3;
    logic [AW-1:0]       cand_addr;
    logic [CW+5:0]       px_ext;
    logic [CW+5:0]       py_ext;
    logic [ZW+3:0]       pz_ext;

    logic                occ_we;
    logic [AW-1:0]       occ_waddr;
    logic                occ_wdata;
    logic                occ_rdata;
    logic                path_we;
    logic [PW-1:0]       path_waddr;
    logic [AW-1:0]       path_rdata;
    logic                rel_rd;
    logic                release_done;
    logic                out_free;

    assign is3d    = i_cfg.dimension_mode;
    assign dir_raw = i_cmd.sel_latched ? r_dir : i_direction;

    always_comb begin
        if (is3d ? (dir_raw >= lwcc_pkg::DIRS_3D) : (dir_raw >= lwcc_pkg::DIRS_2D)) begin
            dir = 3'd0;
        end else begin
            dir = dir_raw;
        end
    end

    always_comb begin
        if (is3d) begin
            dx = lwcc_pkg::delta_of(i_cfg.dx_table_3d, dir);
            dy = lwcc_pkg::delta_of(i_cfg.dy_table_3d, dir);
            dz = lwcc_pkg::delta_of(i_cfg.dz_table_3d, dir);
        end else begin
            dx = lwcc_pkg::delta_of({4'd0, i_cfg.dx_table_2d}, dir);
            dy = lwcc_pkg::delta_of({4'd0, i_cfg.dy_table_2d}, dir);
            dz = 2'sd0;
        end
    end

    // An origin at or past the grid side saturates to the last cell.
    assign org_in  = is3d ? {5'd0, i_cfg.origin_3d} : {3'd0, i_cfg.origin_2d};
    assign side9   = is3d ? 9'(SIDE_3D) : 9'(SIDE_2D);
    assign org_sat = (org_in >= side9) ? (side9 - 9'd1) : org_in;
    assign org     = org_sat[CW-1:0];

    always_comb begin
        if (i_cmd.place_origin) begin
            base_x = org;
            base_y = org;
            base_z = is3d ? org[ZW-1:0] : '0;
            nx     = $signed({2'b00, base_x});
            ny     = $signed({2'b00, base_y});
            nz     = $signed({2'b00, base_z});
        end else begin
            base_x = r_cur_x;
            base_y = r_cur_y;
            base_z = r_cur_z;
            nx     = $signed({2'b00, base_x}) + SW'(dx);
            ny     = $signed({2'b00, base_y}) + SW'(dy);
            nz     = $signed({2'b00, base_z}) + ZSW'(dz);
        end
        if (!is3d) begin
            nz = '0;
        end
    end

    assign side_s = is3d ? SW'(SIDE_3D) : SW'(SIDE_2D);
    assign side_z = ZSW'(SIDE_3D);
    assign oob_x  = nx[SW-1] || (nx >= side_s);
    assign oob_y  = ny[SW-1] || (ny >= side_s);
    assign oob_z  = is3d && (nz[ZSW-1] || (nz >= side_z));
    assign full   = (r_beads >= BW'(MAX_CHAIN));

    assign ux = nx[CW-1:0];
    assign uy = ny[CW-1:0];
    assign uz = nz[ZW-1:0];

    assign addr2     = AW'(ux) * AW'(SIDE_2D) + AW'(uy);
    assign addr3     = (AW'(ux) * AW'(SIDE_3D) + AW'(uy)) * AW'(SIDE_3D) + AW'(uz);
    assign cand_addr = is3d ? addr3 : addr2;

    assign blocked   = oob_x || oob_y || oob_z || full || occ_rdata;
    assign place_now = i_cmd.resolve && !r_failed && !blocked;

    assign rel_rd       = i_cmd.release_run && (r_rel_idx < r_beads);
    assign release_done = i_cmd.release_run && !rel_rd && !r_rel_wr;
    assign out_free     = !r_out_valid || !i_out_stall;

    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = cand_addr;
        occ_wdata = 1'b0;
        if (i_cmd.clear_run) begin
            occ_we    = 1'b1;
            occ_waddr = r_clr_idx;
        end else if (r_rel_wr) begin
            occ_we    = 1'b1;
            occ_waddr = path_rdata;
        end else if (i_cmd.place_origin || place_now) begin
            occ_we    = 1'b1;
            occ_wdata = 1'b1;
        end
    end

    assign path_we    = i_cmd.place_origin || place_now;
    assign path_waddr = i_cmd.place_origin ? '0 : r_beads[PW-1:0];

    lwcc_ram #(
        .WIDTH (1),
        .DEPTH (CELL_DEPTH)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_re    (i_cmd.rd_occ),
        .i_raddr (cand_addr),
        .o_rdata (occ_rdata)
    );

    lwcc_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_CHAIN)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (cand_addr),
        .i_re    (rel_rd),
        .i_raddr (r_rel_idx[PW-1:0]),
        .o_rdata (path_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_z     <= '0;
            r_beads     <= '0;
            r_failed    <= 1'b0;
            r_started   <= 1'b0;
            r_rel_idx   <= '0;
            r_rel_wr    <= 1'b0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_run) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.place_origin || place_now) begin
                r_cur_x <= ux;
                r_cur_y <= uy;
                r_cur_z <= uz;
            end
            if (i_cmd.place_origin) begin
                r_beads   <= BW'(1);
                r_failed  <= 1'b0;
                r_started <= 1'b1;
            end else if (place_now) begin
                r_beads <= r_beads + BW'(1);
            end
            if (i_cmd.resolve) begin
                if (r_last) begin
                    r_started <= 1'b0;
                    r_failed  <= 1'b0;
                end else if (!r_failed && blocked) begin
                    r_failed <= 1'b1;
                end
            end
            r_rel_wr <= rel_rd;
            if (rel_rd) begin
                r_rel_idx <= r_rel_idx + BW'(1);
            end
            if (release_done) begin
                r_rel_idx <= '0;
                r_beads   <= '0;
            end
            if (i_cmd.resolve) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign px_ext = {6'd0, ux};
    assign py_ext = {6'd0, uy};
    assign pz_ext = {4'd0, uz};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_dir  <= i_direction;
            r_last <= i_last_step;
        end
        if (i_cmd.resolve) begin
            r_pos_x     <= place_now ? px_ext[5:0] : 6'd0;
            r_pos_y     <= place_now ? py_ext[5:0] : 6'd0;
            r_pos_z     <= (place_now && is3d) ? pz_ext[3:0] : 4'd0;
            r_chain_end <= r_last;
            if (r_failed) begin
                r_status <= lwcc_pkg::STATUS_SKIPPED;
            end else if (blocked) begin
                r_status <= lwcc_pkg::STATUS_BLOCKED;
            end else begin
                r_status <= lwcc_pkg::STATUS_PLACED;
            end
        end
    end

    assign o_sts.started      = r_started;
    assign o_sts.failed       = r_failed;
    assign o_sts.last         = r_last;
    assign o_sts.out_free     = out_free;
    assign o_sts.release_done = release_done;
    assign o_sts.clear_done   = i_cmd.clear_run && (r_clr_idx == AW'(CELL_DEPTH - 1));

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_step_status = r_status;
    assign o_chain_end   = r_chain_end;

endmodule
`default_nettype wire

// ===== design/lattice_walk_collision_check_core.sv =====
// Top level of the lattice walk collision checker.
// Depends on lwcc_pkg, lwcc_cfg, lwcc_ctrl and lwcc_dp (which holds two lwcc_ram stores).
//
// Channel   Direction  Handshake                Word
// input     in         i_in_valid / o_in_stall  i_direction, i_last_step
// output    out        o_out_valid / i_out_stall o_pos_x, o_pos_y, o_pos_z,
//                                               o_step_status, o_chain_end
// config    in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A move does the occupancy read at accept and the check and write after it.
// The first word of a chain passes through the origin, read and check states, since the origin cell is written first.
// After the last word of a chain the occupancy store is released from the path store,
// one cell per cycle, with o_in_stall high.
// After reset a clearing pass over SIDE_2D**2 or SIDE_3D**3 cells (the larger, 4096 by
// default) holds o_in_stall high. A stalled result holds the block in its check step.
`default_nettype none
module lattice_walk_collision_check_core #(
    parameter int SIDE_2D   = 64,
    parameter int SIDE_3D   = 16,
    parameter int MAX_CHAIN = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [2:0]                  i_direction,
    input  wire logic                        i_last_step,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [5:0]                  o_pos_x,
    output logic      [5:0]                  o_pos_y,
    output logic      [3:0]                  o_pos_z,
    output logic      [1:0]                  o_step_status,
    output logic                             o_chain_end,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lwcc_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    lwcc_pkg::t_cfg cfg;
    lwcc_pkg::t_cmd cmd;
    lwcc_pkg::t_sts sts;

    lwcc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lwcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lwcc_dp #(
        .SIDE_2D   (SIDE_2D),
        .SIDE_3D   (SIDE_3D),
        .MAX_CHAIN (MAX_CHAIN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_direction   (i_direction),
        .i_last_step   (i_last_step),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_step_status (o_step_status),
        .o_chain_end   (o_chain_end)
    );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for lattice_walk_collision_check_core: directed and random walks
// on both lattices, with random gaps and stalls on both channels and APB register writes.
// Depends on lwcc_pkg and the core; predicts every word internally and checks each output word.
module tb_top;

    localparam int SIDE_2D      = 64;
    localparam int SIDE_3D      = 16;
    localparam int MAX_CHAIN    = 64;
    localparam int CELL_COUNT   = 4096;
    localparam int RELEASE_WAIT = MAX_CHAIN + 8;

    typedef struct packed {
        logic [2:0] direction;
        logic       last_step;
        logic       hold;
    } t_move;

    typedef struct packed {
        logic [5:0] pos_x;
        logic [5:0] pos_y;
        logic [3:0] pos_z;
        logic [1:0] status;
        logic       chain_end;
    } t_bead;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [2:0]        move_dir = '0;
    logic              move_last = 1'b0;
    logic              out_stall = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [lwcc_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;

    logic        in_stall;
    logic        out_valid;
    logic [5:0]  pos_x;
    logic [5:0]  pos_y;
    logic [3:0]  pos_z;
    logic [1:0]  step_status;
    logic        chain_end;
    logic [31:0] prdata;
    logic        pready;

    lattice_walk_collision_check_core #(
        .SIDE_2D  (SIDE_2D),
        .SIDE_3D  (SIDE_3D),
        .MAX_CHAIN(MAX_CHAIN)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_direction  (move_dir),
        .i_last_step  (move_last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_pos_x      (pos_x),
        .o_pos_y      (pos_y),
        .o_pos_z      (pos_z),
        .o_step_status(step_status),
        .o_chain_end  (chain_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    t_move pending_moves[$];
    t_bead predicted_beads[$];
    t_move next_move;
    t_bead due_bead;
    lwcc_pkg::t_cfg lattice_cfg;

    bit occupancy[CELL_COUNT];
    int chain_cells[MAX_CHAIN];
    int walk_x, walk_y, walk_z;
    int beads_down;
    bit walk_failed;
    bit walk_started;

    int  mismatches = 0;
    int  results_seen = 0;
    int  queued_total = 0;
    bit  send_gaps = 1'b1;
    bit  recv_stalls = 1'b1;
    bit  took_word = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  next_hold_at = 150;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int step_delta(input logic [11:0] tbl, input logic [2:0] dir);
        logic [1:0] f;
        f = tbl[dir*2 +: 2];
        return f[1] ? int'(f) - 4 : int'(f);
    endfunction

    function automatic int cell_of(input bit is3d, input int x, input int y, input int z);
        if (is3d) return ((x * SIDE_3D + y) * SIDE_3D + z) % CELL_COUNT;
        return (x * SIDE_2D + y) % CELL_COUNT;
    endfunction

    function automatic t_bead advance_walk(input logic [2:0] dir_in, input logic last);
        t_bead      r;
        bit         is3d;
        bit         blocked;
        int         side, org, nx, ny, nz, site;
        logic [2:0] dir;
        r = '0;
        r.chain_end = last;
        is3d = lattice_cfg.dimension_mode;
        side = is3d ? SIDE_3D : SIDE_2D;
        if (!walk_started) begin
            org = is3d ? int'(lattice_cfg.origin_3d) : int'(lattice_cfg.origin_2d);
            if (org >= side) org = side - 1;
            walk_x = org;
            walk_y = org;
            walk_z = is3d ? org : 0;
            chain_cells[0] = cell_of(is3d, walk_x, walk_y, walk_z);
            occupancy[chain_cells[0]] = 1'b1;
            beads_down = 1;
            walk_failed = 1'b0;
            walk_started = 1'b1;
        end
        if (walk_failed) begin
            r.status = lwcc_pkg::STATUS_SKIPPED;
        end else begin
            dir = dir_in;
            if (dir >= (is3d ? lwcc_pkg::DIRS_3D : lwcc_pkg::DIRS_2D)) dir = '0;
            if (is3d) begin
                nx = walk_x + step_delta(lattice_cfg.dx_table_3d, dir);
                ny = walk_y + step_delta(lattice_cfg.dy_table_3d, dir);
                nz = walk_z + step_delta(lattice_cfg.dz_table_3d, dir);
            end else begin
                nx = walk_x + step_delta({4'b0, lattice_cfg.dx_table_2d}, dir);
                ny = walk_y + step_delta({4'b0, lattice_cfg.dy_table_2d}, dir);
                nz = 0;
            end
            blocked = nx < 0 || nx >= side || ny < 0 || ny >= side ||
                      nz < 0 || nz >= side || beads_down >= MAX_CHAIN;
            if (!blocked && occupancy[cell_of(is3d, nx, ny, nz)]) blocked = 1'b1;
            if (blocked) begin
                walk_failed = 1'b1;
                r.status = lwcc_pkg::STATUS_BLOCKED;
            end else begin
                site = cell_of(is3d, nx, ny, nz);
                occupancy[site] = 1'b1;
                chain_cells[beads_down] = site;
                beads_down++;
                walk_x = nx;
                walk_y = ny;
                walk_z = nz;
                r.pos_x = nx[5:0];
                r.pos_y = ny[5:0];
                r.pos_z = is3d ? nz[3:0] : 4'd0;
                r.status = lwcc_pkg::STATUS_PLACED;
            end
        end
        if (last) begin
            for (int k = 0; k < beads_down; k++) occupancy[chain_cells[k]] = 1'b0;
            beads_down = 0;
            walk_failed = 1'b0;
            walk_started = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            predicted_beads.push_back(advance_walk(move_dir, move_last));
            took_word = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || took_word) begin
            took_word = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_moves.size() != 0 &&
                         !(pending_moves[0].hold && predicted_beads.size() != 0)) begin
                next_move = pending_moves.pop_front();
                move_dir <= next_move.direction;
                move_last <= next_move.last_step;
                in_valid <= 1'b1;
                send_gap = send_gaps ? pick_gap() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (results_seen >= next_hold_at) begin
            hold_left = 300;
            next_hold_at += 500;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = recv_stalls ? pick_gap() : 0;
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [5:0] want, input logic [5:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (predicted_beads.size() == 0) begin
                $error("output word with no prediction pending");
                mismatches++;
            end else begin
                due_bead = predicted_beads.pop_front();
                check_field("pos_x", due_bead.pos_x, pos_x);
                check_field("pos_y", due_bead.pos_y, pos_y);
                check_field("pos_z", {2'b0, due_bead.pos_z}, {2'b0, pos_z});
                check_field("step_status", {4'b0, due_bead.status}, {4'b0, step_status});
                check_field("chain_end", {5'b0, due_bead.chain_end}, {5'b0, chain_end});
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lwcc_pkg::REG_DIM_MODE:  lattice_cfg.dimension_mode = val[0];
            lwcc_pkg::REG_DX_2D:     lattice_cfg.dx_table_2d = val[7:0];
            lwcc_pkg::REG_DY_2D:     lattice_cfg.dy_table_2d = val[7:0];
            lwcc_pkg::REG_DX_3D:     lattice_cfg.dx_table_3d = val[11:0];
            lwcc_pkg::REG_DY_3D:     lattice_cfg.dy_table_3d = val[11:0];
            lwcc_pkg::REG_DZ_3D:     lattice_cfg.dz_table_3d = val[11:0];
            lwcc_pkg::REG_ORIGIN_2D: lattice_cfg.origin_2d = val[5:0];
            lwcc_pkg::REG_ORIGIN_3D: lattice_cfg.origin_3d = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_lattice(input int mode, input int dx2, input int dy2, input int dx3,
                               input int dy3, input int dz3, input int o2, input int o3);
        write_reg(lwcc_pkg::REG_DIM_MODE, mode);
        write_reg(lwcc_pkg::REG_DX_2D, dx2);
        write_reg(lwcc_pkg::REG_DY_2D, dy2);
        write_reg(lwcc_pkg::REG_DX_3D, dx3);
        write_reg(lwcc_pkg::REG_DY_3D, dy3);
        write_reg(lwcc_pkg::REG_DZ_3D, dz3);
        write_reg(lwcc_pkg::REG_ORIGIN_2D, o2);
        write_reg(lwcc_pkg::REG_ORIGIN_3D, o3);
    endtask

    task automatic queue_move(input int dir, input bit last, input bit hold = 1'b0);
        t_move m;
        m.direction = 3'(dir);
        m.last_step = last;
        m.hold = hold;
        pending_moves.push_back(m);
        queued_total++;
    endtask

    task automatic drain_walks();
        while (pending_moves.size() != 0 || in_valid || predicted_beads.size() != 0)
            @(posedge clk);
        repeat (RELEASE_WAIT) @(posedge clk);
    endtask

    // Serpentine chains can run long enough to fill the path store; the rest are
    // persistent random walks that mostly end on an edge or a collision.
    task automatic queue_random_chain(input bit serpentine_ok);
        int         pick, len, run, j;
        logic [2:0] d;
        pick = $urandom_range(0, 99);
        if (serpentine_ok && pick < 6) begin
            run = $urandom_range(5, 20);
            len = $urandom_range(40, 72);
            for (int k = 0; k < len; k++) begin
                j = k % (run + 1);
                if (j == run) d = 3'd2;
                else d = ((k / (run + 1)) % 2 == 1) ? 3'd1 : 3'd0;
                queue_move(d, k == len - 1);
            end
        end else begin
            if (pick < 16) len = 1;
            else if (pick < 70) len = $urandom_range(2, 12);
            else len = $urandom_range(13, 40);
            d = 3'($urandom_range(0, 7));
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) >= 60) d = 3'($urandom_range(0, 7));
                queue_move(d, k == len - 1, $urandom_range(0, 149) == 0);
            end
        end
    endtask

    task automatic run_random_phase(input int target, input bit serpentine_ok,
                                    input bit sgaps, input bit rstalls);
        int start_count;
        send_gaps = sgaps;
        recv_stalls = rstalls;
        start_count = queued_total;
        while (queued_total - start_count < target) queue_random_chain(serpentine_ok);
        drain_walks();
    endtask

    initial begin
        lattice_cfg = {lwcc_pkg::RST_DIM_MODE, lwcc_pkg::RST_DX_2D, lwcc_pkg::RST_DY_2D,
                       lwcc_pkg::RST_DX_3D, lwcc_pkg::RST_DY_3D, lwcc_pkg::RST_DZ_3D,
                       lwcc_pkg::RST_ORIGIN_2D, lwcc_pkg::RST_ORIGIN_3D};
        for (int k = 0; k < CELL_COUNT; k++) occupancy[k] = 1'b0;
        walk_x = 0;
        walk_y = 0;
        walk_z = 0;
        beads_down = 0;
        walk_failed = 1'b0;
        walk_started = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_lattice(0, 13, 208, 13, 208, 3328, 32, 8);
        queue_move(0, 0);
        queue_move(1, 0);
        queue_move(2, 0);
        queue_move(7, 1);
        queue_move(4, 0);
        queue_move(5, 0);
        queue_move(6, 0);
        queue_move(7, 0);
        queue_move(2, 0);
        queue_move(3, 1);
        queue_move(3, 1);
        drain_walks();
        write_reg(lwcc_pkg::REG_ORIGIN_2D, 63);
        queue_move(0, 0);
        queue_move(2, 1);
        drain_walks();
        write_reg(lwcc_pkg::REG_ORIGIN_2D, 0);
        queue_move(1, 1);
        drain_walks();
        // The lattice switches to 3D in the middle of a chain.
        write_reg(lwcc_pkg::REG_ORIGIN_2D, 5);
        queue_move(0, 0);
        drain_walks();
        write_reg(lwcc_pkg::REG_DIM_MODE, 1);
        queue_move(4, 0);
        queue_move(6, 0);
        queue_move(7, 1);
        drain_walks();
        write_reg(lwcc_pkg::REG_DIM_MODE, 0);
        queue_move(0, 0);
        queue_move(0, 1);
        drain_walks();

        set_lattice(0, 13, 208, 13, 208, 3328, 32, 8);
        run_random_phase(160, 1, 1, 1);
        set_lattice(1, 13, 208, 13, 208, 3328, 32, 8);
        run_random_phase(160, 0, 0, 1);
        set_lattice(0, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 63), $urandom_range(0, 15));
        run_random_phase(140, 0, 1, 0);
        set_lattice(1, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 63), $urandom_range(0, 15));
        run_random_phase(140, 0, 0, 0);
        set_lattice(0, 255, 0, 4095, 0, 0, 63, 15);
        run_random_phase(120, 0, 1, 1);
        set_lattice(1, 0, 255, 4095, 4095, 4095, 0, 15);
        run_random_phase(120, 0, 1, 1);
        set_lattice(0, 13, 208, 13, 208, 3328, 0, 8);
        run_random_phase(160, 1, 1, 1);
        set_lattice(1, 13, 208, 13, 208, 3328, 32, 0);
        run_random_phase(140, 0, 1, 1);
        set_lattice(0, 13, 208, 13, 208, 3328, $urandom_range(0, 63), 8);
        run_random_phase(160, 1, 0, 0);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
